// File: sv/ltq_pkg.sv
// Shared types and constants for the linked thread queue manager.
package ltq_pkg;

   // default sizes
   localparam int NODES_DEF  = 32;
   localparam int QUEUES_DEF = 8;

   // fixed field widths of the request and response words
   localparam int ACTION_W   = 3;
   localparam int QUEUE_ID_W = 3;
   localparam int NODE_IDX_W = 5;

   // action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_INS_BACK  = 3'd0,
      ACT_INS_FRONT = 3'd1,
      ACT_REM_HEAD  = 3'd2,
      ACT_REM_NODE  = 3'd3,
      ACT_PEEK      = 3'd4
   } action_type;

   // request word
   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [QUEUE_ID_W-1:0] queue_id;
      logic [NODE_IDX_W-1:0] node_index;
   } req_type;

   // response word
   typedef struct packed {
      logic                  found;
      logic [NODE_IDX_W-1:0] node_out;
      logic                  queue_empty;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_TAIL,
      ST_LINK,
      ST_WALK,
      ST_UNLINK,
      ST_RESP
   } state_type;

   // tail table update controls
   typedef struct packed {
      logic set_tail;
      logic set_valid;
      logic clr_valid;
   } tail_upd_type;

endpackage

// File: sv/ltq_ram.sv
// Generic single write port, single read port RAM with registered read.
module ltq_ram
   import ltq_pkg::*;
#(
   parameter int WIDTH = NODE_IDX_W,
   parameter int DEPTH = NODES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, output holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ltq_tail.sv
// Per-queue tail pointer and non-empty flag table.
module ltq_tail
   import ltq_pkg::*;
#(
   parameter int NODES  = NODES_DEF,
   parameter int QUEUES = QUEUES_DEF,
   localparam int NW    = $clog2(NODES),
   localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [QW-1:0] q_idx,
   input  tail_upd_type  upd,
   input  logic [NW-1:0] tail_new,
   output logic [NW-1:0] tail_cur,
   output logic          have
);

   logic [NW-1:0] tail_ff  [QUEUES];
   logic          valid_ff [QUEUES];

   // table update for the addressed queue
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            tail_ff[i]  <= '0;
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (upd.set_tail) begin
            tail_ff[q_idx] <= tail_new;
         end
         if (upd.set_valid) begin
            valid_ff[q_idx] <= 1'b1;
         end else if (upd.clr_valid) begin
            valid_ff[q_idx] <= 1'b0;
         end
      end
   end

   assign tail_cur = tail_ff[q_idx];
   assign have     = valid_ff[q_idx];

endmodule

// File: sv/ltq_ctrl.sv
// Sequencer: decodes a request and steps the link tables through it.
module ltq_ctrl
   import ltq_pkg::*;
#(
   parameter int NODES  = NODES_DEF,
   parameter int QUEUES = QUEUES_DEF,
   localparam int NW    = $clog2(NODES),
   localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1,
   localparam int SW    = $clog2(NODES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output logic          found,
   output logic [NW-1:0] node,
   output logic          q_ok,
   // tail table
   output logic [QW-1:0] q_idx,
   output tail_upd_type  tail_upd,
   output logic [NW-1:0] tail_new,
   input  logic [NW-1:0] tail_cur,
   input  logic          have,
   // link tables: shared read address
   output logic          rd_en,
   output logic [NW-1:0] rd_addr,
   input  logic [NW-1:0] nxt_rdata,
   input  logic [NW-1:0] prv_rdata,
   output logic          nxt_we,
   output logic [NW-1:0] nxt_waddr,
   output logic [NW-1:0] nxt_wdata,
   output logic          prv_we,
   output logic [NW-1:0] prv_waddr,
   output logic [NW-1:0] prv_wdata
);

   state_type             state_ff, state_in;
   logic [ACTION_W-1:0]   act_ff, act_in;
   logic [QUEUE_ID_W-1:0] q_ff, q_in;
   logic                  q_ok_ff, q_ok_in;
   logic [NW-1:0]         blk_ff, blk_in;
   logic                  blk_ok_ff, blk_ok_in;
   logic [SW-1:0]         steps_ff, steps_in;
   logic                  found_ff, found_in;
   logic [NW-1:0]         node_ff, node_in;

   logic accept;
   logic cur_hit;
   logic cur_end;

   assign accept  = start && (state_ff == ST_IDLE);
   // ring walk compares on the link read just returned
   assign cur_hit = (nxt_rdata == blk_ff);
   assign cur_end = (nxt_rdata == tail_cur) || (steps_ff == SW'(NODES));

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      act_ff    <= act_in;
      q_ff      <= q_in;
      q_ok_ff   <= q_ok_in;
      blk_ff    <= blk_in;
      blk_ok_ff <= blk_ok_in;
      steps_ff  <= steps_in;
      found_ff  <= found_in;
      node_ff   <= node_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            if (q_ok_ff) begin
               case (act_ff) inside
                  ACT_INS_BACK, ACT_INS_FRONT: begin
                     if (blk_ok_ff && have) begin
                        state_in = ST_READ_TAIL;
                     end
                  end
                  ACT_REM_HEAD, ACT_PEEK: begin
                     if (have) begin
                        state_in = ST_READ_TAIL;
                     end
                  end
                  ACT_REM_NODE: begin
                     if (have && blk_ok_ff) begin
                        state_in = ST_READ_TAIL;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_READ_TAIL: begin
            state_in = ST_RESP;
            case (act_ff) inside
               ACT_INS_BACK, ACT_INS_FRONT: state_in = ST_LINK;
               ACT_REM_HEAD: begin
                  if (nxt_rdata != tail_cur) begin
                     state_in = ST_UNLINK;
                  end
               end
               ACT_REM_NODE: begin
                  if (blk_ff != tail_cur) begin
                     state_in = ST_WALK;
                  end
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_LINK: state_in = ST_RESP;
         ST_WALK: begin
            if (cur_hit) begin
               state_in = ST_UNLINK;
            end else if (cur_end) begin
               state_in = ST_RESP;
            end
         end
         ST_UNLINK: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and table controls
   always_comb begin
      act_in    = act_ff;
      q_in      = q_ff;
      q_ok_in   = q_ok_ff;
      blk_in    = blk_ff;
      blk_ok_in = blk_ok_ff;
      steps_in  = steps_ff;
      found_in  = found_ff;
      node_in   = node_ff;
      tail_upd  = '0;
      tail_new  = blk_ff;
      rd_en     = 1'b0;
      rd_addr   = tail_cur;
      nxt_we    = 1'b0;
      nxt_waddr = blk_ff;
      nxt_wdata = blk_ff;
      prv_we    = 1'b0;
      prv_waddr = blk_ff;
      prv_wdata = blk_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in    = req_data.action;
               q_in      = req_data.queue_id;
               q_ok_in   = (32'(req_data.queue_id) < QUEUES);
               blk_in    = NW'(req_data.node_index);
               blk_ok_in = (32'(req_data.node_index) < NODES);
               found_in  = 1'b0;
               node_in   = '0;
            end
         end
         ST_DECODE: begin
            if (q_ok_ff) begin
               case (act_ff) inside
                  ACT_INS_BACK, ACT_INS_FRONT: begin
                     if (blk_ok_ff) begin
                        found_in = 1'b1;
                        node_in  = blk_ff;
                        if (have) begin
                           rd_en = 1'b1;
                        end else begin
                           // first block: links to itself
                           nxt_we             = 1'b1;
                           prv_we             = 1'b1;
                           tail_upd.set_tail  = 1'b1;
                           tail_upd.set_valid = 1'b1;
                        end
                     end
                  end
                  ACT_REM_HEAD, ACT_PEEK: rd_en = have;
                  ACT_REM_NODE: rd_en = have && blk_ok_ff;
                  default: rd_en = 1'b0;
               endcase
            end
         end
         ST_READ_TAIL: begin
            // link outputs hold next and prev of the tail
            case (act_ff) inside
               ACT_INS_BACK, ACT_INS_FRONT: begin
                  nxt_we    = 1'b1;
                  nxt_wdata = nxt_rdata;
                  prv_we    = 1'b1;
                  prv_waddr = nxt_rdata;
               end
               ACT_PEEK: begin
                  found_in = 1'b1;
                  node_in  = nxt_rdata;
               end
               ACT_REM_HEAD: begin
                  found_in = 1'b1;
                  if (nxt_rdata == tail_cur) begin
                     node_in            = tail_cur;
                     tail_upd.clr_valid = 1'b1;
                  end else begin
                     node_in = nxt_rdata;
                     rd_en   = 1'b1;
                     rd_addr = nxt_rdata;
                  end
               end
               ACT_REM_NODE: begin
                  if (blk_ff == tail_cur) begin
                     found_in = 1'b1;
                     node_in  = tail_cur;
                     if (nxt_rdata == tail_cur) begin
                        tail_upd.clr_valid = 1'b1;
                     end else begin
                        // predecessor becomes the tail, tail unlinked
                        tail_upd.set_tail = 1'b1;
                        tail_new          = prv_rdata;
                        prv_we            = 1'b1;
                        prv_waddr         = nxt_rdata;
                        prv_wdata         = prv_rdata;
                        nxt_we            = 1'b1;
                        nxt_waddr         = prv_rdata;
                        nxt_wdata         = nxt_rdata;
                     end
                  end else begin
                     steps_in = '0;
                  end
               end
               default: found_in = 1'b0;
            endcase
         end
         ST_LINK: begin
            nxt_we    = 1'b1;
            nxt_waddr = tail_cur;
            prv_we    = 1'b1;
            prv_wdata = tail_cur;
            if (act_ff == ACT_INS_BACK) begin
               tail_upd.set_tail = 1'b1;
            end
         end
         ST_WALK: begin
            // one link per cycle: read address comes from the last read
            rd_addr = nxt_rdata;
            if (cur_hit) begin
               rd_en    = 1'b1;
               found_in = 1'b1;
               node_in  = blk_ff;
            end else if (!cur_end) begin
               rd_en    = 1'b1;
               steps_in = steps_ff + SW'(1);
            end
         end
         ST_UNLINK: begin
            // splice neighbors of the removed block together
            prv_we    = 1'b1;
            prv_waddr = nxt_rdata;
            prv_wdata = prv_rdata;
            nxt_we    = 1'b1;
            nxt_waddr = prv_rdata;
            nxt_wdata = nxt_rdata;
         end
         ST_RESP: begin
            found_in = found_ff;
         end
         default: found_in = found_ff;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);
   assign found      = found_ff;
   assign node       = node_ff;
   assign q_ok       = q_ok_ff;
   assign q_idx      = QW'(q_ff);

endmodule

// File: sv/linked_thread_queue_manager.sv
// Top level: circular doubly linked queues over a pool of thread blocks.
//
// Keeps QUEUES circular doubly linked queues over NODES thread blocks; each
// queue is named by its tail, and its head is the block after the tail. A
// request (start high while busy is low) names an action, a queue and a
// block, and gives exactly one response word, shown for one cycle with
// rsp_strobe; the receiver cannot hold it off, so it must take it then.
// Removal of a named block that is not the tail walks the ring over the
// next-link RAM, one registered read per cycle. busy stays high from
// accept until the strobe cycle ends. Inserting a block that is already
// on a ring is not checked and corrupts the links.
module linked_thread_queue_manager
   import ltq_pkg::*;
#(
   parameter int NODES  = NODES_DEF,
   parameter int QUEUES = QUEUES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int NW = $clog2(NODES);
   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   logic          found;
   logic [NW-1:0] node;
   logic          q_ok;
   logic [QW-1:0] q_idx;
   tail_upd_type  tail_upd;
   logic [NW-1:0] tail_new;
   logic [NW-1:0] tail_cur;
   logic          have;
   logic          rd_en;
   logic [NW-1:0] rd_addr;
   logic [NW-1:0] nxt_rdata;
   logic [NW-1:0] prv_rdata;
   logic          nxt_we;
   logic [NW-1:0] nxt_waddr;
   logic [NW-1:0] nxt_wdata;
   logic          prv_we;
   logic [NW-1:0] prv_waddr;
   logic [NW-1:0] prv_wdata;

   ltq_ctrl #(
      .NODES  (NODES),
      .QUEUES (QUEUES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .found      (found),
      .node       (node),
      .q_ok       (q_ok),
      .q_idx      (q_idx),
      .tail_upd   (tail_upd),
      .tail_new   (tail_new),
      .tail_cur   (tail_cur),
      .have       (have),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .nxt_rdata  (nxt_rdata),
      .prv_rdata  (prv_rdata),
      .nxt_we     (nxt_we),
      .nxt_waddr  (nxt_waddr),
      .nxt_wdata  (nxt_wdata),
      .prv_we     (prv_we),
      .prv_waddr  (prv_waddr),
      .prv_wdata  (prv_wdata)
   );

   ltq_tail #(
      .NODES  (NODES),
      .QUEUES (QUEUES)
   ) u_tail (
      .clock    (clock),
      .reset    (reset),
      .q_idx    (q_idx),
      .upd      (tail_upd),
      .tail_new (tail_new),
      .tail_cur (tail_cur),
      .have     (have)
   );

   // link toward the head
   ltq_ram #(
      .WIDTH (NW),
      .DEPTH (NODES)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_waddr),
      .wr_data (nxt_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (nxt_rdata)
   );

   // link toward the tail
   ltq_ram #(
      .WIDTH (NW),
      .DEPTH (NODES)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_waddr),
      .wr_data (prv_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prv_rdata)
   );

   // response word; a queue number out of range reads as empty
   always_comb begin
      rsp_data.found       = found;
      rsp_data.node_out    = NODE_IDX_W'(node);
      rsp_data.queue_empty = !q_ok || !have;
   end

endmodule

// File: tb/ltq_reply_check.sv
// Reply checker for the linked thread queue manager: models the rings and compares each reply.
`timescale 1ns / 100ps

module ltq_reply_check
   import ltq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      replies_due
);

   // model of the link tables and tail registers
   bit [NODE_IDX_W-1:0] next_blk [NODES_DEF];
   bit [NODE_IDX_W-1:0] prev_blk [NODES_DEF];
   bit [NODE_IDX_W-1:0] tail_blk [QUEUES_DEF];
   bit                  tail_live [QUEUES_DEF];

   // reply words owed by the block, oldest first
   rsp_type queue_op_replies [$];
   rsp_type oldest;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // take a block out of whatever ring it sits on
   function automatic void unlink_block(input bit [NODE_IDX_W-1:0] n);
      bit [NODE_IDX_W-1:0] a, b;
      a = prev_blk[n];
      b = next_blk[n];
      prev_blk[b] = a;
      next_blk[a] = b;
   endfunction

   // apply one request word to the model and return the reply word it yields
   function automatic rsp_type model_queue_op(input req_type w);
      rsp_type             r;
      bit [NODE_IDX_W-1:0] t, blk, head, cur;
      bit                  have;
      int                  steps;
      r    = '0;
      t    = tail_blk[w.queue_id];
      blk  = w.node_index;
      have = tail_live[w.queue_id];
      case (w.action)
         ACT_INS_BACK, ACT_INS_FRONT: begin
            if (!have) begin
               // first block links to itself
               next_blk[blk]           = blk;
               prev_blk[blk]           = blk;
               tail_blk[w.queue_id]  = blk;
               tail_live[w.queue_id] = 1'b1;
            end else begin
               // splice between tail and head; write order matters on misuse
               head           = next_blk[t];
               next_blk[blk]  = head;
               prev_blk[head] = blk;
               next_blk[t]    = blk;
               prev_blk[blk]  = t;
               if (w.action == ACT_INS_BACK) tail_blk[w.queue_id] = blk;
            end
            r.found    = 1'b1;
            r.node_out = blk;
         end
         ACT_REM_HEAD: begin
            if (have) begin
               head = next_blk[t];
               if (head == t) begin
                  tail_live[w.queue_id] = 1'b0;
               end else begin
                  unlink_block(head);
               end
               r.found    = 1'b1;
               r.node_out = head;
            end
         end
         ACT_REM_NODE: begin
            if (have) begin
               if (blk == t) begin
                  // tail goes, its predecessor takes over
                  if (next_blk[t] == t) begin
                     tail_live[w.queue_id] = 1'b0;
                  end else begin
                     tail_blk[w.queue_id] = prev_blk[t];
                     unlink_block(t);
                  end
                  r.found    = 1'b1;
                  r.node_out = t;
               end else begin
                  // bounded walk from the head
                  cur   = next_blk[t];
                  steps = 0;
                  while (cur != blk && cur != t && steps < NODES_DEF) begin
                     cur = next_blk[cur];
                     steps++;
                  end
                  if (cur == blk) begin
                     unlink_block(blk);
                     r.found    = 1'b1;
                     r.node_out = blk;
                  end
               end
            end
         end
         ACT_PEEK: begin
            if (have) begin
               r.found    = 1'b1;
               r.node_out = next_blk[t];
            end
         end
         default: ;
      endcase
      r.queue_empty = !tail_live[w.queue_id];
      return r;
   endfunction

   // watch both channels; reply side first, a word never lands on its own accept edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (next_blk[i]) begin
            next_blk[i] = '0;
            prev_blk[i] = '0;
         end
         foreach (tail_blk[i]) begin
            tail_blk[i]  = '0;
            tail_live[i] = 1'b0;
         end
         queue_op_replies.delete();
      end else begin
         if (rsp_strobe) begin
            if (queue_op_replies.size() == 0) begin
               report_mismatch("reply with nothing owed", rsp_data, 0);
            end else begin
               oldest = queue_op_replies.pop_front();
               if (rsp_data.found !== oldest.found)
                  report_mismatch("found", rsp_data.found, oldest.found);
               if (rsp_data.node_out !== oldest.node_out)
                  report_mismatch("node_out", rsp_data.node_out, oldest.node_out);
               if (rsp_data.queue_empty !== oldest.queue_empty)
                  report_mismatch("queue_empty", rsp_data.queue_empty, oldest.queue_empty);
            end
         end
         if (start && !busy) queue_op_replies.push_back(model_queue_op(req_data));
      end
      replies_due = queue_op_replies.size();
   end

endmodule

// File: tb/tb.sv
// Testbench top for the linked thread queue manager: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import ltq_pkg::*;

   // action codes the block leaves unused
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
   localparam int FREE_BLOCK = -1;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int mismatches;
   int replies_due;

   // sender pacing and share of inserts that ignore block ownership
   int idle_pct;
   int misuse_pct;

   // which queue each block is believed to sit on
   int                  block_owner [NODES_DEF];
   logic [ACTION_W-1:0] last_action;

   linked_thread_queue_manager dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   ltq_reply_check reply_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .replies_due (replies_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop
   initial begin
      #1000000;
      $display("tb NOT OK");
      $finish;
   end

   // free blocks as removals come back
   always @(posedge clock) begin
      if (start && !busy) last_action <= req_data.action;
      if (rsp_strobe && rsp_data.found &&
          (last_action == ACT_REM_HEAD || last_action == ACT_REM_NODE))
         block_owner[rsp_data.node_out] = FREE_BLOCK;
   end

   function automatic req_type req_word(input logic [ACTION_W-1:0] act, input int q,
                                        input int n);
      req_type w;
      w.action     = act;
      w.queue_id   = QUEUE_ID_W'(q);
      w.node_index = NODE_IDX_W'(n);
      return w;
   endfunction

   // random block owned by want, or FREE_BLOCK when none is
   function automatic int pick_block(input int want);
      int first, b;
      first = $urandom_range(NODES_DEF - 1);
      for (int i = 0; i < NODES_DEF; i++) begin
         b = (first + i) % NODES_DEF;
         if (block_owner[b] == want) return b;
      end
      return FREE_BLOCK;
   endfunction

   // mostly well-formed traffic, biased to two queues so rings grow long
   function automatic req_type random_word();
      req_type w;
      int      q, sel, b;
      q = ($urandom_range(99) < 60) ? $urandom_range(1) : $urandom_range(QUEUES_DEF - 1);
      sel = $urandom_range(99);
      w.queue_id   = QUEUE_ID_W'(q);
      w.node_index = NODE_IDX_W'($urandom_range(NODES_DEF - 1));
      if (sel < 40) begin
         w.action = (sel < 25) ? ACT_INS_BACK : ACT_INS_FRONT;
         b = pick_block(FREE_BLOCK);
         if ($urandom_range(99) < misuse_pct) b = w.node_index;
         if (b == FREE_BLOCK) begin
            w.action = ACT_REM_HEAD;
         end else begin
            w.node_index   = NODE_IDX_W'(b);
            block_owner[b] = q;
         end
      end else if (sel < 58) begin
         w.action = ACT_REM_HEAD;
      end else if (sel < 83) begin
         w.action = ACT_REM_NODE;
         if ($urandom_range(99) < 75) begin
            b = pick_block(q);
            if (b != FREE_BLOCK) w.node_index = NODE_IDX_W'(b);
         end
      end else if (sel < 95) begin
         w.action = ACT_PEEK;
      end else begin
         w.action = ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      end
      return w;
   endfunction

   // present one word, optionally after an idle gap, and return on its accept edge
   task automatic send_word(input req_type w);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      req_type directed [$];
      start      <= 1'b0;
      req_data   <= '0;
      reset      <= 1'b1;
      idle_pct   = 8;
      misuse_pct = 0;
      foreach (block_owner[i]) block_owner[i] = FREE_BLOCK;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty queue, unused codes, extremes of queue and block numbers
      directed.push_back(req_word(ACT_PEEK, 3, 31));
      directed.push_back(req_word(ACT_REM_HEAD, 3, 0));
      directed.push_back(req_word(ACT_REM_NODE, 3, 4));
      directed.push_back(req_word(ACT_UNUSED_LO, 3, 0));
      directed.push_back(req_word(ACT_INS_BACK, 7, 31));
      directed.push_back(req_word(ACT_INS_BACK, 7, 0));
      directed.push_back(req_word(ACT_INS_FRONT, 7, 17));
      directed.push_back(req_word(ACT_PEEK, 7, 0));
      // absent block, then tail removal handing over to its predecessor
      directed.push_back(req_word(ACT_REM_NODE, 7, 9));
      directed.push_back(req_word(ACT_REM_NODE, 7, 0));
      directed.push_back(req_word(ACT_UNUSED_HI, 7, 31));
      directed.push_back(req_word(ACT_REM_HEAD, 7, 31));
      directed.push_back(req_word(ACT_REM_HEAD, 7, 0));
      // front insert into empty queue, reinsert of a block already there
      directed.push_back(req_word(ACT_INS_FRONT, 0, 5));
      directed.push_back(req_word(ACT_INS_BACK, 0, 5));
      directed.push_back(req_word(ACT_REM_NODE, 0, 5));
      // block stolen by a second queue leaves a ring the walk cannot close
      directed.push_back(req_word(ACT_INS_BACK, 0, 1));
      directed.push_back(req_word(ACT_INS_BACK, 0, 2));
      directed.push_back(req_word(ACT_INS_BACK, 1, 1));
      directed.push_back(req_word(ACT_REM_NODE, 0, 7));
      directed.push_back(req_word(ACT_REM_NODE, 0, 2));
      directed.push_back(req_word(ACT_REM_HEAD, 0, 0));
      directed.push_back(req_word(ACT_REM_HEAD, 1, 0));
      foreach (directed[i]) send_word(directed[i]);

      // three pacing phases; the last one also misuses inserts now and then
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct   = (phase == 0) ? 8 : (phase == 1) ? 47 : 0;
         misuse_pct = (phase == 2) ? 2 : 0;
         repeat (300) send_word(random_word());
      end
      start <= 1'b0;

      // drain, then allow one full walk of latency
      while (replies_due != 0) @(posedge clock);
      repeat (NODES_DEF + 10) @(posedge clock);
      if (mismatches == 0 && replies_due == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
